// ===== hdl/vau_pkg.sv =====
// Shared definitions for the three-component vector arithmetic unit.
// Holds the action codes and the control bundle passed along the pipeline.
// No dependencies.
package vau_pkg;

  localparam int ACT_W = 4;

  typedef enum logic [ACT_W-1:0] {
    ACT_ADD   = 4'd0,
    ACT_SUB   = 4'd1,
    ACT_SCALE = 4'd2,
    ACT_DIV   = 4'd3,
    ACT_NEG   = 4'd4,
    ACT_DOT   = 4'd5,
    ACT_LENSQ = 4'd6,
    ACT_LEN   = 4'd7,
    ACT_NORM  = 4'd8
  } action_t;

  typedef struct packed {
    action_t act;
    logic    dz;
    logic    zlen;
    logic    ovf;
  } ctl_t;

endpackage

// ===== hdl/vau_lane.sv =====
// One component lane of the vector unit: add, subtract, negate and the
// per-component product, with rounding and saturation. Uses vau_pkg.
module vau_lane import vau_pkg::*; #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          en,
  input  action_t                       act,
  input  logic signed [WORD_BITS-1:0]   a,
  input  logic signed [WORD_BITS-1:0]   b,
  input  logic signed [WORD_BITS-1:0]   f,
  output logic signed [2*WORD_BITS-1:0] prod,
  output logic signed [WORD_BITS-1:0]   vec,
  output logic                          vec_ovf
);

  localparam int W  = WORD_BITS;
  localparam int PW = 2 * WORD_BITS;
  localparam logic signed [PW:0] HALF = (PW+1)'(1) <<< (FRAC_BITS - 1);
  localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};

  action_t                act_r;
  logic signed [W-1:0]    mul_op;
  logic signed [W:0]      simp_nxt;
  logic signed [W:0]      simp_r;
  logic signed [PW-1:0]   prod_r;
  logic signed [PW:0]     rnd;
  logic signed [PW:0]     rsh;
  logic signed [PW:0]     sat_in;
  logic [PW-W+1:0]        hi;
  logic                   in_rng;
  logic signed [W-1:0]    vec_nxt;
  logic signed [W-1:0]    vec_r;
  logic                   ovf_nxt;
  logic                   ovf_r;

  always_comb begin
    mul_op   = a;
    simp_nxt = '0;
    unique case (act)
      ACT_ADD:   simp_nxt = (W+1)'(a) + (W+1)'(b);
      ACT_SUB:   simp_nxt = (W+1)'(a) - (W+1)'(b);
      ACT_NEG:   simp_nxt = -((W+1)'(a));
      ACT_SCALE: mul_op = f;
      ACT_DOT:   mul_op = b;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      act_r  <= act;
      prod_r <= a * mul_op;
      simp_r <= simp_nxt;
    end
  end

  always_comb begin
    rnd    = (PW+1)'(prod_r) + HALF;
    rsh    = rnd >>> FRAC_BITS;
    sat_in = '0;
    unique case (act_r)
      ACT_ADD, ACT_SUB, ACT_NEG: sat_in = (PW+1)'(simp_r);
      ACT_SCALE:                 sat_in = rsh;
      default:                   ;
    endcase
    hi      = sat_in[PW:W-1];
    in_rng  = (&hi) | ~(|hi);
    vec_nxt = in_rng ? sat_in[W-1:0] : (sat_in[PW] ? MINV : MAXV);
    ovf_nxt = !in_rng;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec_r <= vec_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  assign prod    = prod_r;
  assign vec     = vec_r;
  assign vec_ovf = ovf_r;

endmodule

// ===== hdl/vau_sqrt.sv =====
// Pipelined square root, one root bit per stage, followed by a
// round-to-nearest stage. Standalone; no package dependencies.
module vau_sqrt #(
  parameter int WORD_BITS = 32
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [2*WORD_BITS+1:0]   s,
  output logic [WORD_BITS:0]       len
);

  localparam int SW = 2 * WORD_BITS + 2;
  localparam int RW = WORD_BITS + 1;

  logic [SW-1:0] rem_r  [RW];
  logic [RW-1:0] root_r [RW];
  logic [RW-1:0] len_r;

  for (genvar j = 0; j < RW; j++) begin : g_stage
    localparam int BIT = RW - 1 - j;
    logic [SW-1:0] rem_p;
    logic [RW-1:0] root_p;
    logic [SW:0]   trial;
    logic          ge;

    if (j == 0) begin : g_first
      assign rem_p  = s;
      assign root_p = '0;
    end else begin : g_rest
      assign rem_p  = rem_r[j-1];
      assign root_p = root_r[j-1];
    end

    assign trial = ((SW+1)'(root_p) << (BIT + 1)) | ((SW+1)'(1) << (2 * BIT));
    assign ge    = {1'b0, rem_p} >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j]  <= ge ? (rem_p - trial[SW-1:0]) : rem_p;
        root_r[j] <= ge ? (root_p | (RW'(1) << BIT)) : root_p;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      len_r <= root_r[RW-1] + RW'(rem_r[RW-1] > SW'(root_r[RW-1]));
    end
  end

  assign len = len_r;

endmodule

// ===== hdl/vau_div.sv =====
// Pipelined restoring divider for one lane, one quotient bit per stage,
// with half-away rounding, sign and saturation. No package dependencies.
module vau_div #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic [WORD_BITS+FRAC_BITS-1:0]  num,
  input  logic [WORD_BITS:0]              den,
  input  logic                            neg,
  output logic signed [WORD_BITS-1:0]     q,
  output logic                            q_ovf
);

  localparam int W  = WORD_BITS;
  localparam int NW = WORD_BITS + FRAC_BITS;
  localparam int DW = WORD_BITS + 1;
  localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};

  logic [NW-1:0] sh_r  [NW];
  logic [DW-1:0] rem_r [NW];
  logic [DW-1:0] den_r [NW];
  logic          neg_r [NW];

  for (genvar j = 0; j < NW; j++) begin : g_stage
    logic [NW-1:0] sh_p;
    logic [DW-1:0] rem_p;
    logic [DW-1:0] den_p;
    logic          neg_p;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    if (j == 0) begin : g_first
      assign sh_p  = num;
      assign rem_p = '0;
      assign den_p = den;
      assign neg_p = neg;
    end else begin : g_rest
      assign sh_p  = sh_r[j-1];
      assign rem_p = rem_r[j-1];
      assign den_p = den_r[j-1];
      assign neg_p = neg_r[j-1];
    end

    assign trial = {rem_p, sh_p[NW-1]};
    assign ge    = trial >= {1'b0, den_p};
    assign diff  = trial - {1'b0, den_p};

    always_ff @(posedge clk) begin
      if (en) begin
        sh_r[j]  <= {sh_p[NW-2:0], ge};
        rem_r[j] <= ge ? diff[DW-1:0] : trial[DW-1:0];
        den_r[j] <= den_p;
        neg_r[j] <= neg_p;
      end
    end
  end

  logic                 up;
  logic [NW:0]          qr;
  logic signed [NW+1:0] qs;
  logic [NW-W+2:0]      hi;
  logic                 in_rng;
  logic signed [W-1:0]  q_r;
  logic                 ovf_r;

  always_comb begin
    up     = rem_r[NW-1] >= (den_r[NW-1] - rem_r[NW-1]);
    qr     = (NW+1)'(sh_r[NW-1]) + (NW+1)'(up);
    qs     = neg_r[NW-1] ? -$signed({1'b0, qr}) : $signed({1'b0, qr});
    hi     = qs[NW+1:W-1];
    in_rng = (&hi) | ~(|hi);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r   <= in_rng ? qs[W-1:0] : (qs[NW+1] ? MINV : MAXV);
      ovf_r <= !in_rng;
    end
  end

  assign q     = q_r;
  assign q_ovf = ovf_r;

endmodule

// ===== hdl/vector3_arithmetic_unit_core.sv =====
// Three-component vector unit in signed fixed point (Q16.16 by default).
// One item enters per cycle while no result waits untaken at the output, and
// every item passes the front stages, then the square-root pipeline
// (WORD_BITS+2 stages) and then the per-lane divider pipelines
// (WORD_BITS+FRAC_BITS+1 stages), in order. While the
// output register holds a result that is not taken, the whole pipeline holds.
// Uses vau_pkg, vau_lane, vau_sqrt and vau_div.
module vector3_arithmetic_unit_core import vau_pkg::*; #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  // ax, ay, az, bx, by, bz, factor
  input  logic [((7*WORD_BITS+7)/8)*8-1:0]        in_tdata,
  // action
  input  logic [ACT_W-1:0]                        in_tuser,
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  // rx, ry, rz, scalar_out
  output logic [((4*WORD_BITS+7)/8)*8-1:0]        out_tdata,
  // div_zero, overflow
  output logic [1:0]                              out_tuser
);

  localparam int W      = WORD_BITS;
  localparam int PW     = 2 * WORD_BITS;
  localparam int SW     = 2 * WORD_BITS + 2;
  localparam int RW     = WORD_BITS + 1;
  localparam int NW     = WORD_BITS + FRAC_BITS;
  localparam int SQ_LAT = RW + 1;
  localparam int DV_LAT = NW + 1;
  localparam int N_STG  = 2 + SQ_LAT + DV_LAT;
  localparam int OUT_DW = ((4*WORD_BITS+7)/8)*8;
  localparam logic signed [SW-1:0] SHALF = SW'(1) <<< (FRAC_BITS - 1);
  localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};

  logic                  en;
  action_t               act_in;
  logic signed [W-1:0]   in_a [3];
  logic signed [W-1:0]   in_b [3];
  logic signed [W-1:0]   in_f;
  logic [N_STG-1:0]      vld_r;
  logic                  out_valid_r;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;
  assign act_in    = action_t'(in_tuser);
  assign in_f      = in_tdata[6*W +: W];

  logic signed [PW-1:0]  prod    [3];
  logic signed [W-1:0]   lane_v  [3];
  logic                  lane_o  [3];

  for (genvar i = 0; i < 3; i++) begin : g_lane
    assign in_a[i] = in_tdata[i*W +: W];
    assign in_b[i] = in_tdata[(3+i)*W +: W];

    vau_lane #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_lane (
      .clk     (clk),
      .en      (en),
      .act     (act_in),
      .a       (in_a[i]),
      .b       (in_b[i]),
      .f       (in_f),
      .prod    (prod[i]),
      .vec     (lane_v[i]),
      .vec_ovf (lane_o[i])
    );
  end

  // Front stages: operands ride beside the lanes, the dot sum is merged here.
  action_t               act_a_r, act_b_r;
  logic signed [W-1:0]   a_a_r [3];
  logic signed [W-1:0]   a_b_r [3];
  logic signed [W-1:0]   f_a_r, f_b_r;
  logic signed [SW-1:0]  sum_r;

  always_ff @(posedge clk) begin
    if (en) begin
      act_a_r <= act_in;
      a_a_r   <= in_a;
      f_a_r   <= in_f;
      act_b_r <= act_a_r;
      a_b_r   <= a_a_r;
      f_b_r   <= f_a_r;
      sum_r   <= SW'(prod[0]) + SW'(prod[1]) + SW'(prod[2]);
    end
  end

  logic signed [SW-1:0]  srnd, srsh;
  logic [SW-W:0]         shi;
  logic                  s_rng;
  logic signed [W-1:0]   scal_nxt;
  logic                  sovf_nxt;

  always_comb begin
    srnd     = sum_r + SHALF;
    srsh     = srnd >>> FRAC_BITS;
    shi      = srsh[SW-1:W-1];
    s_rng    = (&shi) | ~(|shi);
    scal_nxt = '0;
    sovf_nxt = 1'b0;
    if (act_b_r == ACT_DOT || act_b_r == ACT_LENSQ) begin
      scal_nxt = s_rng ? srsh[W-1:0] : (srsh[SW-1] ? MINV : MAXV);
      sovf_nxt = !s_rng;
    end
  end

  logic [RW-1:0] len;

  vau_sqrt #(.WORD_BITS(WORD_BITS)) u_sqrt (
    .clk (clk),
    .en  (en),
    .s   (sum_r),
    .len (len)
  );

  // Payload alongside the square-root pipeline.
  action_t               p1_act  [SQ_LAT];
  logic signed [W-1:0]   p1_a    [SQ_LAT][3];
  logic signed [W-1:0]   p1_f    [SQ_LAT];
  logic signed [W-1:0]   p1_vec  [SQ_LAT][3];
  logic signed [W-1:0]   p1_scal [SQ_LAT];
  logic                  p1_ovf  [SQ_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      p1_act[0]  <= act_b_r;
      p1_a[0]    <= a_b_r;
      p1_f[0]    <= f_b_r;
      p1_vec[0]  <= lane_v;
      p1_scal[0] <= scal_nxt;
      p1_ovf[0]  <= lane_o[0] | lane_o[1] | lane_o[2] | sovf_nxt;
      for (int k = 1; k < SQ_LAT; k++) begin
        p1_act[k]  <= p1_act[k-1];
        p1_a[k]    <= p1_a[k-1];
        p1_f[k]    <= p1_f[k-1];
        p1_vec[k]  <= p1_vec[k-1];
        p1_scal[k] <= p1_scal[k-1];
        p1_ovf[k]  <= p1_ovf[k-1];
      end
    end
  end

  action_t             d_act;
  logic signed [W-1:0] d_f;
  logic [W-1:0]        f_mag;
  logic [RW-1:0]       d_den;
  logic                len_big;
  ctl_t                ctl_nxt;
  logic signed [W-1:0] scal2_nxt;

  always_comb begin
    d_act   = p1_act[SQ_LAT-1];
    d_f     = p1_f[SQ_LAT-1];
    f_mag   = d_f[W-1] ? W'(-d_f) : W'(d_f);
    d_den   = (d_act == ACT_DIV) ? {1'b0, f_mag} : len;
    len_big = |len[RW-1:W-1];
    scal2_nxt    = p1_scal[SQ_LAT-1];
    ctl_nxt.act  = d_act;
    ctl_nxt.dz   = (d_act == ACT_DIV) && (d_f == '0);
    ctl_nxt.zlen = (len == '0);
    ctl_nxt.ovf  = p1_ovf[SQ_LAT-1];
    if (d_act == ACT_LEN) begin
      scal2_nxt   = len_big ? MAXV : len[W-1:0];
      ctl_nxt.ovf = len_big;
    end
  end

  logic signed [W-1:0] q     [3];
  logic                q_ovf [3];

  for (genvar i = 0; i < 3; i++) begin : g_div
    logic signed [W-1:0] av;
    logic [W-1:0]        a_mag;

    assign av    = p1_a[SQ_LAT-1][i];
    assign a_mag = av[W-1] ? W'(-av) : W'(av);

    vau_div #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div (
      .clk   (clk),
      .en    (en),
      .num   ({a_mag, {FRAC_BITS{1'b0}}}),
      .den   (d_den),
      .neg   (av[W-1] ^ ((d_act == ACT_DIV) & d_f[W-1])),
      .q     (q[i]),
      .q_ovf (q_ovf[i])
    );
  end

  // Payload alongside the divider pipelines.
  ctl_t                p2_ctl  [DV_LAT];
  logic signed [W-1:0] p2_vec  [DV_LAT][3];
  logic signed [W-1:0] p2_scal [DV_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      p2_ctl[0]  <= ctl_nxt;
      p2_vec[0]  <= p1_vec[SQ_LAT-1];
      p2_scal[0] <= scal2_nxt;
      for (int k = 1; k < DV_LAT; k++) begin
        p2_ctl[k]  <= p2_ctl[k-1];
        p2_vec[k]  <= p2_vec[k-1];
        p2_scal[k] <= p2_scal[k-1];
      end
    end
  end

  ctl_t                fc;
  logic signed [W-1:0] rv [3];
  logic signed [W-1:0] rs;
  logic                rdz, rovf;

  always_comb begin
    fc   = p2_ctl[DV_LAT-1];
    rv   = p2_vec[DV_LAT-1];
    rs   = p2_scal[DV_LAT-1];
    rdz  = 1'b0;
    rovf = fc.ovf;
    unique case (fc.act)
      ACT_DIV: begin
        rs = '0;
        if (fc.dz) begin
          rv   = '{default: '0};
          rdz  = 1'b1;
          rovf = 1'b0;
        end else begin
          rv   = q;
          rovf = q_ovf[0] | q_ovf[1] | q_ovf[2];
        end
      end
      ACT_NORM: begin
        rs = '0;
        if (fc.zlen) begin
          rv   = '{default: '0};
          rovf = 1'b0;
        end else begin
          rv   = q;
          rovf = q_ovf[0] | q_ovf[1] | q_ovf[2];
        end
      end
      default: ;
    endcase
  end

  logic signed [W-1:0] rx_r, ry_r, rz_r, rs_r;
  logic                dz_r, ovf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[N_STG-2:0], in_tvalid};
      out_valid_r <= vld_r[N_STG-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rx_r  <= rv[0];
      ry_r  <= rv[1];
      rz_r  <= rv[2];
      rs_r  <= rs;
      dz_r  <= rdz;
      ovf_r <= rovf;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DW'({rs_r, rz_r, ry_r, rx_r});
  assign out_tuser  = {ovf_r, dz_r};

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && dz_r |-> (rx_r == '0) && (ry_r == '0) && (rz_r == '0) &&
                            (rs_r == '0) && !ovf_r)
    else $error("divide-by-zero result is not a clean zero vector");

  a_scalar_ops: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[N_STG-1] && en &&
    (fc.act == ACT_DOT || fc.act == ACT_LENSQ || fc.act == ACT_LEN)
    |=> (rx_r == '0) && (ry_r == '0) && (rz_r == '0) && !dz_r)
    else $error("scalar operation produced a nonzero vector");

  a_vector_ops: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[N_STG-1] && en &&
    (fc.act == ACT_ADD || fc.act == ACT_SUB || fc.act == ACT_SCALE ||
     fc.act == ACT_NEG || fc.act == ACT_NORM)
    |=> (rs_r == '0) && !dz_r)
    else $error("vector operation produced a scalar or divide-by-zero flag");

endmodule

// ===== tb/tb_vector3_arithmetic_unit_core.sv =====
// Self-checking testbench for vector3_arithmetic_unit_core: directed and random vector
// operations, checked per transfer against a built-in fixed-point predictor.
// Depends on vau_pkg and the vector3_arithmetic_unit_core RTL.
module tb_vector3_arithmetic_unit_core;
  import vau_pkg::*;

  localparam int W = 32;
  localparam int FB = 16;
  localparam int N_RANDOM = 430;
  localparam int TAIL = 80;

  typedef logic signed [127:0] wide_t;
  typedef logic signed [W-1:0] word_t;

  typedef struct {
    logic [ACT_W-1:0] act;
    word_t a[3];
    word_t b[3];
    word_t f;
  } vec_op_t;

  typedef struct {
    word_t r[3];
    word_t s;
    logic dz;
    logic ovf;
  } vec_res_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [((7*W+7)/8)*8-1:0] in_tdata = '0;
  logic [ACT_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [((4*W+7)/8)*8-1:0] out_tdata;
  logic [1:0] out_tuser;

  vec_op_t pending_ops[$];
  vec_res_t expected_results[$];
  vec_op_t cur_op;
  int total_ops = 0;
  int accepted_ops = 0;
  int checked_results = 0;
  int errors = 0;
  int send_gap = 0;
  int recv_gap = 0;
  bit long_hold_done = 0;
  int stall_seen = 0;

  vector3_arithmetic_unit_core #(.WORD_BITS(W), .FRAC_BITS(FB)) DUT (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic word_t clamp_word(wide_t v, inout logic ovf);
    wide_t lo, hi;
    lo = -(wide_t'(1) <<< (W-1));
    hi = (wide_t'(1) <<< (W-1)) - 1;
    if (v < lo) begin
      ovf = 1;
      return lo[W-1:0];
    end
    if (v > hi) begin
      ovf = 1;
      return hi[W-1:0];
    end
    return v[W-1:0];
  endfunction

  function automatic wide_t round_product(wide_t p);
    return (p + (wide_t'(1) <<< (FB-1))) >>> FB;
  endfunction

  function automatic word_t fixed_divide(wide_t num, wide_t den, inout logic ovf);
    logic neg;
    logic [127:0] n, d, q, rem;
    neg = (num < 0) != (den < 0);
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    q = n / d;
    rem = n % d;
    if (rem >= d - rem) q = q + 1;
    return clamp_word(neg ? -wide_t'(q) : wide_t'(q), ovf);
  endfunction

  function automatic wide_t rounded_root(wide_t s);
    logic [127:0] r, c;
    r = 0;
    for (int k = 34; k >= 0; k--) begin
      c = r | (128'd1 << k);
      if (c * c <= s) r = c;
    end
    if (s - r * r > r) r = r + 1;
    return wide_t'(r);
  endfunction

  function automatic vec_res_t predict_vector(vec_op_t op);
    vec_res_t res;
    logic ovf;
    wide_t acc, len;
    ovf = 0;
    res.r = '{default: '0};
    res.s = '0;
    res.dz = 0;
    acc = 0;
    case (op.act)
      ACT_ADD, ACT_SUB: begin
        for (int i = 0; i < 3; i++)
          res.r[i] = clamp_word(op.act == ACT_ADD ? wide_t'(op.a[i]) + wide_t'(op.b[i])
                                                  : wide_t'(op.a[i]) - wide_t'(op.b[i]), ovf);
      end
      ACT_SCALE: begin
        for (int i = 0; i < 3; i++)
          res.r[i] = clamp_word(round_product(wide_t'(op.a[i]) * wide_t'(op.f)), ovf);
      end
      ACT_DIV: begin
        if (op.f == 0) res.dz = 1;
        else
          for (int i = 0; i < 3; i++)
            res.r[i] = fixed_divide(wide_t'(op.a[i]) <<< FB, wide_t'(op.f), ovf);
      end
      ACT_NEG: begin
        for (int i = 0; i < 3; i++) res.r[i] = clamp_word(-wide_t'(op.a[i]), ovf);
      end
      ACT_DOT, ACT_LENSQ, ACT_LEN, ACT_NORM: begin
        for (int i = 0; i < 3; i++)
          acc = acc + wide_t'(op.a[i]) * wide_t'(op.act == ACT_DOT ? op.b[i] : op.a[i]);
        if (op.act == ACT_DOT || op.act == ACT_LENSQ) begin
          res.s = clamp_word(round_product(acc), ovf);
        end else begin
          len = rounded_root(acc);
          if (op.act == ACT_LEN) res.s = clamp_word(len, ovf);
          else if (len != 0)
            for (int i = 0; i < 3; i++)
              res.r[i] = fixed_divide(wide_t'(op.a[i]) <<< FB, len, ovf);
        end
      end
      default: ;
    endcase
    res.ovf = ovf;
    return res;
  endfunction

  function automatic word_t pick_value();
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 6))
          0: return 32'sh8000_0000;
          1: return 32'sh7fff_ffff;
          2: return 0;
          3: return 32'sh0001_0000;
          4: return -32'sh0001_0000;
          5: return 1;
          default: return -1;
        endcase
      end
      1, 2: return word_t'($signed($urandom_range(0, 32'h003f_ffff)) - 32'sh0020_0000);
      default: return word_t'($urandom);
    endcase
  endfunction

  task automatic add_op(logic [ACT_W-1:0] act, word_t ax, word_t ay, word_t az,
                        word_t bx, word_t by, word_t bz, word_t f);
    vec_op_t op;
    op.act = act;
    op.a = '{ax, ay, az};
    op.b = '{bx, by, bz};
    op.f = f;
    pending_ops.push_back(op);
    total_ops++;
  endtask

  task automatic report_mismatch(string field, logic [W-1:0] got, logic [W-1:0] want);
    errors++;
    $display("mismatch on result %0d field %s: got %h expected %h",
             checked_results, field, got, want);
  endtask

  initial begin
    word_t mx, mn, one;
    vec_op_t op;
    mx = 32'sh7fff_ffff;
    mn = 32'sh8000_0000;
    one = 32'sh0001_0000;
    add_op(ACT_ADD, mx, mn, one, mx, mn, -one, 0);
    add_op(ACT_SUB, mx, mn, 0, mn, mx, 0, 0);
    add_op(ACT_SCALE, mx, mn, one, 0, 0, 0, mx);
    add_op(ACT_SCALE, mn, 1, -1, 0, 0, 0, mn);
    add_op(ACT_SCALE, 32'sh8000, -32'sh8000, 3, 0, 0, 0, 32'sh8000);
    add_op(ACT_DIV, one, mx, mn, 0, 0, 0, 0);
    add_op(ACT_DIV, mx, mn, one, 0, 0, 0, 1);
    add_op(ACT_DIV, 3, -3, one, 0, 0, 0, 32'sh0002_0000);
    add_op(ACT_DIV, mn, mx, -one, 0, 0, 0, mn);
    add_op(ACT_NEG, mn, mx, 0, 0, 0, 0, 0);
    add_op(ACT_DOT, mx, mn, mx, mx, mn, mx, 0);
    add_op(ACT_DOT, one, one, one, -one, one, 0, 0);
    add_op(ACT_LENSQ, mn, mn, mn, 0, 0, 0, 0);
    add_op(ACT_LENSQ, one, 2*one, 0, 0, 0, 0, 0);
    add_op(ACT_LEN, mn, mn, mn, 0, 0, 0, 0);
    add_op(ACT_LEN, 3*one, 4*one, 0, 0, 0, 0, 0);
    add_op(ACT_LEN, 0, 0, 0, 0, 0, 0, 0);
    add_op(ACT_NORM, 0, 0, 0, mx, mx, mx, mx);
    add_op(ACT_NORM, 1, 0, 0, 0, 0, 0, 0);
    add_op(ACT_NORM, mn, mx, 1, 0, 0, 0, 0);
    add_op(4'd9, mx, mx, mx, mx, mx, mx, mx);
    add_op(4'd15, mn, 1, -1, 1, -1, mn, 0);
    for (int i = 0; i < N_RANDOM; i++) begin
      if ($urandom_range(0, 9) == 0) op.act = 4'($urandom_range(9, 15));
      else op.act = 4'($urandom_range(0, 8));
      for (int k = 0; k < 3; k++) begin
        op.a[k] = pick_value();
        op.b[k] = pick_value();
      end
      op.f = pick_value();
      if (op.act == ACT_DIV && $urandom_range(0, 4) == 0) op.f = 0;
      if (op.act == ACT_NORM && $urandom_range(0, 5) == 0) op.a = '{default: '0};
      add_op(op.act, op.a[0], op.a[1], op.a[2], op.b[0], op.b[1], op.b[2], op.f);
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_results.push_back(predict_vector(cur_op));
        accepted_ops++;
      end
      if (in_tvalid && !in_tready) begin
        stall_seen++;
      end else if (send_gap > 0) begin
        send_gap--;
        in_tvalid <= 0;
      end else if (pending_ops.size() > 0) begin
        cur_op = pending_ops.pop_front();
        in_tdata <= {cur_op.f, cur_op.b[2], cur_op.b[1], cur_op.b[0],
                     cur_op.a[2], cur_op.a[1], cur_op.a[0]};
        in_tuser <= cur_op.act;
        in_tvalid <= 1;
        if (accepted_ops < total_ops - TAIL && $urandom_range(0, 5) == 0)
          send_gap = $urandom_range(1, 10);
      end else begin
        in_tvalid <= 0;
      end
    end
  end

  always @(posedge clk) begin
    vec_res_t want;
    if (!rst_n) begin
      out_tready <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          errors++;
          $display("unexpected result transfer %h", out_tdata);
        end else begin
          want = expected_results.pop_front();
          for (int i = 0; i < 3; i++)
            if (out_tdata[i*W +: W] !== want.r[i])
              report_mismatch($sformatf("r%0d", i), out_tdata[i*W +: W], want.r[i]);
          if (out_tdata[3*W +: W] !== want.s)
            report_mismatch("scalar_out", out_tdata[3*W +: W], want.s);
          if (out_tuser[0] !== want.dz)
            report_mismatch("div_zero", W'(out_tuser[0]), W'(want.dz));
          if (out_tuser[1] !== want.ovf)
            report_mismatch("overflow", W'(out_tuser[1]), W'(want.ovf));
          checked_results++;
        end
      end
      if (!long_hold_done && accepted_ops >= 150) begin
        long_hold_done = 1;
        recv_gap = 300;
        out_tready <= 0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_tready <= 0;
      end else if (accepted_ops < total_ops - TAIL && $urandom_range(0, 5) == 0) begin
        recv_gap = $urandom_range(0, 9);
        out_tready <= 0;
      end else begin
        out_tready <= 1;
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    wait (total_ops > 0 && pending_ops.size() == 0 && accepted_ops == total_ops
          && expected_results.size() == 0);
    repeat (120) @(posedge clk);
    $display("Covered %0d transfers over all actions, unknown codes, saturation and zero",
             checked_results);
    $display("divisors, with %0d input stall cycles under output back-pressure.", stall_seen);
    if (errors == 0 && expected_results.size() == 0)
      $display("vector3_arithmetic_unit_core regression: pass");
    else
      $display("vector3_arithmetic_unit_core regression: fail");
    $finish;
  end

  initial begin
    #200000;
    $display("vector3_arithmetic_unit_core regression: fail");
    $finish;
  end

endmodule
